[src/rgbu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbu_pkg
// Shared types and constants for the RGBA to unorm8 pixel converter.
// ----------------------------------------------------------------------------
package rgbu_pkg;

   localparam int unsigned ChanWidth = 32;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned AddrWidth = 3;
   localparam int unsigned DataWidth = 32;

   // Source format codes.
   typedef enum logic [1:0] {
      FMT_FLOAT32 = 2'd0,
      FMT_UINT32  = 2'd1,
      FMT_HALF    = 2'd2,
      FMT_UNKNOWN = 2'd3
   } fmt_type;

   // Register index of the format register.
   localparam logic REG_SOURCE_FORMAT = 1'b0;

   // Half exponent rebias (0x1C000 >> 10).
   localparam logic [7:0] HalfRebias = 8'd112;
   // Exponent at which the unrounded product needs no shift.
   localparam logic [7:0] ExpNoShift = 8'd150;

   typedef struct packed {
      logic [ChanWidth-1:0] chan_red;
      logic [ChanWidth-1:0] chan_green;
      logic [ChanWidth-1:0] chan_blue;
      logic [ChanWidth-1:0] chan_alpha;
   } pixel_in_type;

   typedef struct packed {
      logic [ByteWidth-1:0] byte_red;
      logic [ByteWidth-1:0] byte_green;
      logic [ByteWidth-1:0] byte_blue;
      logic [ByteWidth-1:0] byte_alpha;
   } pixel_out_type;

endpackage

[src/rgbu_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbu_csr
// Register file holding the source format, with an APB-style access port.
// ----------------------------------------------------------------------------
module rgbu_csr
   import rgbu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [AddrWidth-1:0] paddr,
   input  logic [DataWidth-1:0] pwdata,
   output logic [DataWidth-1:0] prdata,
   output logic                 pready,
   output fmt_type              source_format
);

   fmt_type fmt_ff;
   fmt_type fmt_in;
   logic    wr_hit;

   // A write lands in the access phase when the index selects the register.
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_SOURCE_FORMAT);

   always_comb begin
      fmt_in = fmt_ff;
      if (wr_hit) begin
         fmt_in = fmt_type'(pwdata[1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_FLOAT32;
      end else begin
         fmt_ff <= fmt_in;
      end
   end

   // Reads return the register, zero elsewhere.
   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_SOURCE_FORMAT) begin
         prdata = {{(DataWidth-2){1'b0}}, fmt_ff};
      end
   end

   assign pready        = 1'b1;
   assign source_format = fmt_ff;

endmodule

[src/rgbu_chan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbu_chan
// Converts one channel word to an 8-bit unorm byte for the selected format.
// ----------------------------------------------------------------------------
module rgbu_chan
   import rgbu_pkg::*;
(
   input  fmt_type              source_format,
   input  logic [ChanWidth-1:0] chan,
   output logic [ByteWidth-1:0] unorm
);

   logic [31:0] fbits;
   logic        sgn;
   logic [7:0]  expo;
   logic [22:0] frac;
   logic [31:0] prod;
   logic [23:0] kept;
   logic        guard;
   logic        sticky;
   logic        rnd_up;
   logic [32:0] rnd;
   logic [8:0]  rsh;
   logic [32:0] ival;
   logic [ByteWidth-1:0] fconv;

   // Half values widen by concatenation; the rebiased exponent never carries.
   always_comb begin
      if (source_format == FMT_HALF) begin
         fbits = {chan[15], {3'b000, chan[14:10]} + HalfRebias, chan[9:0], 13'd0};
      end else begin
         fbits = chan;
      end
   end

   assign sgn  = fbits[31];
   assign expo = fbits[30:23];
   assign frac = fbits[22:0];

   // Exact significand times 255.
   assign prod = {1'b0, 1'b1, frac, 7'd0} + {1'b1, frac, 8'd0} - {8'd0, 1'b1, frac}
                 - {1'b0, 1'b1, frac, 7'd0};

   // Round the product to 24 significant bits, nearest even.
   always_comb begin
      if (prod[31]) begin
         kept   = prod[31:8];
         guard  = prod[7];
         sticky = |prod[6:0];
      end else begin
         kept   = prod[30:7];
         guard  = prod[6];
         sticky = |prod[5:0];
      end
      rnd_up = guard && (sticky || kept[0]);
      if (prod[31]) begin
         rnd = {({1'b0, kept} + {24'd0, rnd_up}), 8'd0};
      end else begin
         rnd = {1'b0, ({1'b0, kept} + {24'd0, rnd_up}), 7'd0};
      end
   end

   // Scale by the exponent, truncate and saturate.
   always_comb begin
      rsh  = {1'b0, ExpNoShift} - {1'b0, expo};
      ival = '0;
      if (!rsh[8] && (rsh < 9'd33)) begin
         ival = rnd >> rsh[5:0];
      end
      if (sgn || (expo == 8'd0)) begin
         fconv = '0;
      end else if (expo == 8'hFF) begin
         fconv = (frac == '0) ? 8'hFF : 8'h00;
      end else if (rsh[8] || (rsh == 9'd0) || (ival >= 33'd255)) begin
         fconv = 8'hFF;
      end else begin
         fconv = ival[7:0];
      end
   end

   always_comb begin
      case (source_format)
         FMT_FLOAT32: unorm = fconv;
         FMT_HALF:    unorm = fconv;
         FMT_UINT32:  unorm = chan[7:0];
         default:     unorm = '0;
      endcase
   end

endmodule

[src/rgba_to_unorm8_convert.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_to_unorm8_convert
// Converts one RGBA pixel per cycle to four unorm8 bytes while rsp is not stalled.
//
//   Channel   Ports                              Direction
//   req       req_valid/req_ready/req_data       pixel in
//   rsp       rsp_valid/rsp_ready/rsp_data       bytes out
//   csr       psel/penable/pwrite/paddr/...      format register
//
// Each transaction passes through two registers: input register, then result register.
// One pixel is taken every cycle unless the result stalls; throughput is set by the result register.
// Reset clears both valid flags and sets the format to float32.
// A stalled result holds; the input stage keeps accepting until it is full.
// ----------------------------------------------------------------------------
module rgba_to_unorm8_convert
   import rgbu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pixel_in_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pixel_out_type        rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [AddrWidth-1:0] paddr,
   input  logic [DataWidth-1:0] pwdata,
   output logic [DataWidth-1:0] prdata,
   output logic                 pready
);

   fmt_type       source_format;
   logic          in_vld_ff, in_vld_in;
   pixel_in_type  in_dat_ff, in_dat_in;
   logic          out_vld_ff, out_vld_in;
   pixel_out_type out_dat_ff, out_dat_in;
   logic          advance;
   pixel_out_type conv;

   rgbu_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata,
      .prdata, .pready, .source_format
   );

   // Four independent channel converters.
   rgbu_chan u_red   (.source_format, .chan(in_dat_ff.chan_red),   .unorm(conv.byte_red));
   rgbu_chan u_green (.source_format, .chan(in_dat_ff.chan_green), .unorm(conv.byte_green));
   rgbu_chan u_blue  (.source_format, .chan(in_dat_ff.chan_blue),  .unorm(conv.byte_blue));
   rgbu_chan u_alpha (.source_format, .chan(in_dat_ff.chan_alpha), .unorm(conv.byte_alpha));

   // Pipeline flow control.
   assign advance   = !out_vld_ff || rsp_ready;
   assign req_ready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_dat_in  = in_dat_ff;
      out_vld_in = out_vld_ff;
      out_dat_in = out_dat_ff;
      if (advance) begin
         out_vld_in = in_vld_ff;
         out_dat_in = conv;
      end
      if (req_ready) begin
         in_vld_in = req_valid;
         in_dat_in = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_dat_ff  <= in_dat_in;
      out_dat_ff <= out_dat_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_dat_ff;

endmodule
